// ===== sv/wcos_pkg.sv =====
// Package for the 2.4 GHz channel overlap selector.
// Holds the channel constants, the overlap weight table and the controller command type.
// No dependencies.
package wcos_pkg;

  localparam int NUM_CHANNELS = 14;
  localparam int USE_WIDTH    = 20;
  localparam int USE_OUT_W    = 20;
  localparam int OVL_W        = 32;
  localparam int FREQ_W       = 13;
  localparam int LEVEL_W      = 8;
  localparam int CH_W         = $clog2(NUM_CHANNELS);
  localparam int WEIGHT_W     = 7;
  localparam int ADD_W        = 9;

  localparam logic [FREQ_W-1:0] FREQ_CH1    = 13'd2412;
  localparam logic [FREQ_W-1:0] FREQ_CH14   = 13'd2484;
  localparam logic [FREQ_W-1:0] FREQ_STEP   = 13'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_POS_MAX = 8'd64;
  localparam logic signed [ADD_W-1:0] WEIGHTED_BASE = 9'sd100;

  localparam logic [CH_W-1:0] IDX_CH12  = 4'd11;
  localparam logic [CH_W-1:0] IDX_CH13  = 4'd12;
  localparam logic [CH_W-1:0] IDX_CH14  = 4'd13;
  localparam logic [CH_W-1:0] IDX_LAST  = 4'd13;

  localparam logic [WEIGHT_W-1:0] W_D0 = 7'd100;
  localparam logic [WEIGHT_W-1:0] W_D1 = 7'd77;
  localparam logic [WEIGHT_W-1:0] W_D2 = 7'd54;
  localparam logic [WEIGHT_W-1:0] W_D3 = 7'd31;
  localparam logic [WEIGHT_W-1:0] W_D4 = 7'd9;
  localparam logic [WEIGHT_W-1:0] W_14_12 = 7'd22;
  localparam logic [WEIGHT_W-1:0] W_14_13 = 7'd45;

  typedef struct packed {
    logic            accum;
    logic            mac;
    logic            row_end;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] k;
    logic [CH_W-1:0] emit_idx;
    logic            clear;
  } cmd_t;

  function automatic logic [FREQ_W-1:0] chan_freq(int i);
    logic [FREQ_W-1:0] f;
    if (i == NUM_CHANNELS - 1) begin
      f = FREQ_CH14;
    end else begin
      f = FREQ_CH1 + FREQ_W'(i) * FREQ_STEP;
    end
    return f;
  endfunction

  function automatic logic [WEIGHT_W-1:0] overlap_weight(logic [CH_W-1:0] c,
                                                          logic [CH_W-1:0] k);
    logic [CH_W-1:0] d;
    logic [CH_W-1:0] other;
    logic [WEIGHT_W-1:0] w;
    d = (c > k) ? (c - k) : (k - c);
    other = (c == IDX_CH14) ? k : c;
    if (c == IDX_CH14 || k == IDX_CH14) begin
      case (other)
        IDX_CH12: w = W_14_12;
        IDX_CH13: w = W_14_13;
        IDX_CH14: w = W_D0;
        default:  w = '0;
      endcase
    end else begin
      case (d)
        4'd0:    w = W_D0;
        4'd1:    w = W_D1;
        4'd2:    w = W_D2;
        4'd3:    w = W_D3;
        4'd4:    w = W_D4;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== sv/wcos_if.sv =====
// Channel interfaces of the channel overlap selector: scan entries, results, configuration.
// Depends on wcos_pkg for field widths.
interface wcos_in_if;
  logic                        valid;
  logic                        ready;
  logic [wcos_pkg::FREQ_W-1:0]  freq_mhz;
  logic [wcos_pkg::LEVEL_W-1:0] level_raw;
  logic                        entry_valid;
  logic                        last_entry;
  modport source (output valid, freq_mhz, level_raw, entry_valid, last_entry, input ready);
  modport sink   (input valid, freq_mhz, level_raw, entry_valid, last_entry, output ready);
endinterface

interface wcos_out_if;
  logic                                valid;
  logic                                ready;
  logic [wcos_pkg::CH_W-1:0]           channel_number;
  logic signed [wcos_pkg::USE_OUT_W-1:0] channel_use;
  logic signed [wcos_pkg::OVL_W-1:0]   overlap_hundredths;
  logic                                is_best;
  logic                                last_result;
  modport source (output valid, channel_number, channel_use, overlap_hundredths, is_best,
                  last_result, input ready);
  modport sink   (input valid, channel_number, channel_use, overlap_hundredths, is_best,
                  last_result, output ready);
endinterface

interface wcos_cfg_if;
  logic valid;
  logic ready;
  logic weighted_mode;
  modport source (output valid, weighted_mode, input ready);
  modport sink   (input valid, weighted_mode, output ready);
endinterface

// ===== sv/wcos_ctrl.sv =====
// Controller of the channel overlap selector: accumulate, multiply-accumulate sweep, emission.
// Depends on wcos_pkg for cmd_t and channel constants.
module wcos_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output wcos_pkg::cmd_t cmd_o
);
  import wcos_pkg::*;

  localparam logic [1:0] S_ACCUM = 2'd0;
  localparam logic [1:0] S_CALC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CH_W-1:0] c_q, c_d;
  logic [CH_W-1:0] k_q, k_d;
  logic [CH_W-1:0] e_q, e_d;
  logic            in_fire;
  logic            out_fire;

  assign in_ready_o  = (state_q == S_ACCUM);
  assign out_valid_o = (state_q == S_EMIT);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    k_d     = k_q;
    e_d     = e_q;
    case (state_q)
      S_ACCUM: begin
        if (in_fire && in_last_i) begin
          state_d = S_CALC;
          c_d     = '0;
          k_d     = '0;
        end
      end
      S_CALC: begin
        if (k_q == IDX_LAST) begin
          k_d = '0;
          c_d = c_q + 1'b1;
          if (c_q == IDX_LAST) begin
            state_d = S_FLUSH;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_FLUSH: begin
        state_d = S_EMIT;
        e_d     = '0;
      end
      S_EMIT: begin
        if (out_fire) begin
          e_d = e_q + 1'b1;
          if (e_q == IDX_LAST) begin
            state_d = S_ACCUM;
          end
        end
      end
      default: state_d = S_ACCUM;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.accum    = in_fire;
    cmd_o.mac      = (state_q == S_CALC);
    cmd_o.row_end  = (k_q == IDX_LAST);
    cmd_o.ch       = c_q;
    cmd_o.k        = k_q;
    cmd_o.emit_idx = e_q;
    cmd_o.clear    = out_fire && (e_q == IDX_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACCUM;
      c_q     <= '0;
      k_q     <= '0;
      e_q     <= '0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      k_q     <= k_d;
      e_q     <= e_d;
    end
  end

endmodule

// ===== sv/wcos_dp.sv =====
// Datapath of the channel overlap selector: per-channel utilization lanes, one multiply-
// accumulate unit, overlap store and running minimum. Depends on wcos_pkg.
module wcos_dp #(
  parameter int USE_WIDTH = wcos_pkg::USE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wcos_pkg::cmd_t                      cmd_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_weighted_i,
  input  logic [wcos_pkg::FREQ_W-1:0]         freq_mhz_i,
  input  logic [wcos_pkg::LEVEL_W-1:0]        level_raw_i,
  input  logic                                entry_valid_i,
  output logic [wcos_pkg::CH_W-1:0]           channel_number_o,
  output logic signed [wcos_pkg::USE_OUT_W-1:0] channel_use_o,
  output logic signed [wcos_pkg::OVL_W-1:0]   overlap_hundredths_o,
  output logic                                is_best_o,
  output logic                                last_result_o
);
  import wcos_pkg::*;

  localparam int PROD_W = USE_WIDTH + WEIGHT_W + 1;
  localparam int ACC_W  = USE_WIDTH + 9;
  localparam int SAT_W  = (ACC_W > OVL_W) ? ACC_W : OVL_W;
  localparam int UX_W   = (USE_WIDTH > USE_OUT_W) ? USE_WIDTH : USE_OUT_W;

  localparam logic signed [SAT_W-1:0] OVL_MAX = {{(SAT_W-OVL_W+1){1'b0}}, {(OVL_W-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] OVL_MIN = ~OVL_MAX;
  localparam logic signed [UX_W-1:0]  UOUT_MAX =
    {{(UX_W-USE_OUT_W+1){1'b0}}, {(USE_OUT_W-1){1'b1}}};
  localparam logic signed [UX_W-1:0]  UOUT_MIN = ~UOUT_MAX;
  localparam logic signed [USE_WIDTH-1:0] USE_MAX = {1'b0, {(USE_WIDTH-1){1'b1}}};
  localparam logic signed [USE_WIDTH-1:0] USE_MIN = ~USE_MAX;

  logic                        mode_q;
  logic signed [USE_WIDTH-1:0] use_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]     hit;
  logic signed [ADD_W-1:0]     add_val;
  logic signed [ADD_W-1:0]     rssi;

  logic signed [PROD_W-1:0]    prod_q;
  logic                        prod_vld_q;
  logic                        prod_end_q;
  logic [CH_W-1:0]             prod_ch_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [ACC_W-1:0]     acc_sum;
  logic signed [SAT_W-1:0]     acc_x;
  logic signed [OVL_W-1:0]     ovl_sat;
  logic signed [OVL_W-1:0]     ovl_q [NUM_CHANNELS];
  logic signed [OVL_W-1:0]     min_q;
  logic signed [USE_WIDTH-1:0] use_sel;
  logic signed [UX_W-1:0]      use_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_weighted_i;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      hit[i] = cmd_i.accum && entry_valid_i && (freq_mhz_i == chan_freq(i));
    end
    if (level_raw_i > LEVEL_POS_MAX) begin
      rssi = $signed({1'b1, level_raw_i});
    end else begin
      rssi = $signed({1'b0, level_raw_i});
    end
    add_val = mode_q ? (WEIGHTED_BASE + rssi) : 9'sd1;
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
    logic signed [USE_WIDTH:0] sum_ext;
    assign sum_ext = {use_q[i][USE_WIDTH-1], use_q[i]}
                   + {{(USE_WIDTH+1-ADD_W){add_val[ADD_W-1]}}, add_val};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        use_q[i] <= '0;
      end else if (cmd_i.clear) begin
        use_q[i] <= '0;
      end else if (hit[i]) begin
        if (sum_ext[USE_WIDTH] != sum_ext[USE_WIDTH-1]) begin
          use_q[i] <= sum_ext[USE_WIDTH] ? USE_MIN : USE_MAX;
        end else begin
          use_q[i] <= sum_ext[USE_WIDTH-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= use_q[cmd_i.k] * $signed({1'b0, overlap_weight(cmd_i.ch, cmd_i.k)});
    prod_end_q <= cmd_i.row_end;
    prod_ch_q  <= cmd_i.ch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac;
    end
  end

  always_comb begin
    acc_sum = acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    acc_x   = {{(SAT_W-ACC_W){acc_sum[ACC_W-1]}}, acc_sum};
    if (acc_x > OVL_MAX) begin
      ovl_sat = OVL_MAX[OVL_W-1:0];
    end else if (acc_x < OVL_MIN) begin
      ovl_sat = OVL_MIN[OVL_W-1:0];
    end else begin
      ovl_sat = acc_x[OVL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= prod_end_q ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_vld_q && prod_end_q) begin
      ovl_q[prod_ch_q] <= ovl_sat;
      if (prod_ch_q == '0) begin
        min_q <= ovl_sat;
      end else if (prod_ch_q != IDX_LAST && ovl_sat < min_q) begin
        min_q <= ovl_sat;
      end
    end
  end

  always_comb begin
    use_sel = use_q[cmd_i.emit_idx];
    use_x   = {{(UX_W-USE_WIDTH){use_sel[USE_WIDTH-1]}}, use_sel};
    if (use_x > UOUT_MAX) begin
      channel_use_o = UOUT_MAX[USE_OUT_W-1:0];
    end else if (use_x < UOUT_MIN) begin
      channel_use_o = UOUT_MIN[USE_OUT_W-1:0];
    end else begin
      channel_use_o = use_x[USE_OUT_W-1:0];
    end
    channel_number_o     = cmd_i.emit_idx + 1'b1;
    overlap_hundredths_o = ovl_q[cmd_i.emit_idx];
    is_best_o            = (ovl_q[cmd_i.emit_idx] <= min_q);
    last_result_o        = (cmd_i.emit_idx == IDX_LAST);
  end

endmodule

// ===== sv/wifi_channel_overlap_selector.sv =====
// Top level of the 2.4 GHz channel overlap selector.
// Depends on wcos_pkg, the interfaces in wcos_if.sv, wcos_ctrl and wcos_dp.
//
// Scan entries arrive on in_i (valid/ready). Each accepted entry with entry_valid
// set and a known channel frequency adds to that channel's utilization, so
// entries stream at one per cycle while in_i is ready. The entry flagged
// last_entry starts the overlap computation: one multiply-accumulate unit walks
// 14 channels by 14 weights and drains its product register; in_i is not ready.
// Then 14 results, channels 1 to 14, leave on out_i (valid/ready); the result
// of channel 14 carries last_result. A stalled receiver simply holds the
// current result; the next one follows once it is taken. After the last
// result the utilization store is cleared and in_i is ready again.
// A last item thus occupies the block for the computation and 14 result
// transactions.
// cfg_i is always ready and sets weighted_mode; write it only while idle.
// Reset clears the utilization store, the mode and all control state.
module wifi_channel_overlap_selector #(
  parameter int USE_WIDTH = wcos_pkg::USE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wcos_in_if.sink           in_i,
  wcos_out_if.source        out_o,
  wcos_cfg_if.sink          cfg_i
);
  import wcos_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  wcos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last_entry),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  wcos_dp #(
    .USE_WIDTH (USE_WIDTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_we_i             (cfg_i.valid),
    .cfg_weighted_i       (cfg_i.weighted_mode),
    .freq_mhz_i           (in_i.freq_mhz),
    .level_raw_i          (in_i.level_raw),
    .entry_valid_i        (in_i.entry_valid),
    .channel_number_o     (out_o.channel_number),
    .channel_use_o        (out_o.channel_use),
    .overlap_hundredths_o (out_o.overlap_hundredths),
    .is_best_o            (out_o.is_best),
    .last_result_o        (out_o.last_result)
  );

endmodule
